// ===== hw/rtl/fpba_pkg.sv =====
// Shared types, sizes and codes for the fit-policy block allocator.
`timescale 1ns / 1ps
`default_nettype none
package fpba_pkg;

	localparam int NUM_BLOCKS = 16;
	localparam int SIZE_BITS  = 16;

	// fixed field widths
	localparam int IDXF_W = 4;
	localparam int AMT_W  = 16;
	localparam int CNT_W  = 5;
	localparam int MODE_W = 2;

	localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int WIDE_W = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;
	localparam int CMP_W  = (IDX_W + 1 > CNT_W) ?
		((IDX_W + 1 > IDXF_W) ? IDX_W + 1 : IDXF_W) :
		((CNT_W > IDXF_W) ? CNT_W : IDXF_W);

	// APB register map
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_FIT_MODE    = 1'b0;
	localparam logic REG_BLOCK_COUNT = 1'b1;

	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

	localparam logic [MODE_W-1:0] FIT_MODE_RST    = MODE_FIRST;
	localparam logic [CNT_W-1:0]  BLOCK_COUNT_RST = 5'd16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} state_t;

	// broadcast to every cell
	typedef struct packed {
		logic [MODE_W-1:0]    mode;
		logic [WIDE_W-1:0]    amount;
		logic [CNT_W-1:0]     count;
		logic                 wr_en;
		logic [IDX_W-1:0]     wr_idx;
		logic [SIZE_BITS-1:0] wr_data;
	} cell_ctl_t;

	// best candidate handed down the chain
	typedef struct packed {
		logic                 found;
		logic [IDX_W-1:0]     idx;
		logic [SIZE_BITS-1:0] cap;
	} cand_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fpba_cell.sv =====
// One table cell: holds one block's capacity and refines the running candidate.
`timescale 1ns / 1ps
`default_nettype none
module fpba_cell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [fpba_pkg::IDX_W-1:0]    my_idx,
	input  wire fpba_pkg::cell_ctl_t           ctl,
	input  wire fpba_pkg::cand_t               cand_in,
	output fpba_pkg::cand_t                    cand_out
);

	logic [fpba_pkg::SIZE_BITS-1:0] cap_q;
	logic                           cand_found_q;
	logic [fpba_pkg::IDX_W-1:0]     cand_idx_q;
	logic [fpba_pkg::SIZE_BITS-1:0] cand_cap_q;
	logic                           in_use;
	logic                           fits;
	logic                           take;

	always_comb begin
		in_use = fpba_pkg::CMP_W'(my_idx) < fpba_pkg::CMP_W'(ctl.count);
		fits   = in_use && (fpba_pkg::WIDE_W'(cap_q) >= ctl.amount);
		if (!cand_in.found) begin
			take = fits;
		end else if (ctl.mode == fpba_pkg::MODE_BEST) begin
			take = fits && (cap_q < cand_in.cap);
		end else if (ctl.mode == fpba_pkg::MODE_WORST) begin
			take = fits && (cap_q > cand_in.cap);
		end else begin
			take = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
		end else if (ctl.wr_en && (ctl.wr_idx == my_idx)) begin
			cap_q <= ctl.wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_found_q <= 1'b0;
		end else begin
			cand_found_q <= cand_in.found | take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cand_idx_q <= my_idx;
			cand_cap_q <= cap_q;
		end else begin
			cand_idx_q <= cand_in.idx;
			cand_cap_q <= cand_in.cap;
		end
	end

	assign cand_out = {cand_found_q, cand_idx_q, cand_cap_q};

endmodule
`default_nettype wire

// ===== hw/rtl/fpba_cfg.sv =====
// APB register file: placement policy and number of blocks in use.
`timescale 1ns / 1ps
`default_nettype none
module fpba_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [fpba_pkg::PADDR_W-1:0]      paddr,
	input  wire logic [fpba_pkg::PDATA_W-1:0]      pwdata,
	output logic [fpba_pkg::PDATA_W-1:0]           prdata,
	output logic                                   pready,
	output logic [fpba_pkg::MODE_W-1:0]            fit_mode,
	output logic [fpba_pkg::CNT_W-1:0]             block_count
);

	logic [fpba_pkg::MODE_W-1:0] fit_mode_q;
	logic [fpba_pkg::CNT_W-1:0]  block_count_q;
	logic                        wr;
	logic                        reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[fpba_pkg::PADDR_W-1];
	assign wr      = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q    <= fpba_pkg::FIT_MODE_RST;
			block_count_q <= fpba_pkg::BLOCK_COUNT_RST;
		end else if (wr) begin
			unique case (reg_sel)
				fpba_pkg::REG_FIT_MODE: begin
					fit_mode_q <= pwdata[fpba_pkg::MODE_W-1:0];
				end
				fpba_pkg::REG_BLOCK_COUNT: begin
					block_count_q <= pwdata[fpba_pkg::CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			fpba_pkg::REG_FIT_MODE:    prdata = fpba_pkg::PDATA_W'(fit_mode_q);
			fpba_pkg::REG_BLOCK_COUNT: prdata = fpba_pkg::PDATA_W'(block_count_q);
			default:                   prdata = '0;
		endcase
	end

	assign fit_mode    = fit_mode_q;
	assign block_count = block_count_q;

endmodule
`default_nettype wire

// ===== hw/rtl/fit_policy_block_allocator_core.sv =====
// Top level: capacity table as a chain of cells, request sequencer, result register.
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake            Word
// in        into core  in_valid / in_stall  action, block_index, amount
// out       from core  out_valid / out_stall granted, chosen_block, left_over
// cfg       into core  APB psel/penable     fit_mode @0x0, block_count @0x4
//
// A load word writes its cell at the accept edge.
// A request runs through the accept cycle, then the candidate walks the
// NUM_BLOCKS-cell chain one cell per cycle, then the charge cycle charges the
// block and loads the result into the output register.
// in_stall is high while a request is in flight; a finished result sits in
// the output register, so the next word is taken while it waits.
// The final charge cycle holds while the output register is full and stalled.
// Reset clears every capacity, fit_mode to first fit, block_count to 16.
module fit_policy_block_allocator_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// input words
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              action,
	input  wire logic [fpba_pkg::IDXF_W-1:0]       block_index,
	input  wire logic [fpba_pkg::AMT_W-1:0]        amount,
	// result words
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   granted,
	output logic [fpba_pkg::IDXF_W-1:0]            chosen_block,
	output logic [fpba_pkg::AMT_W-1:0]             left_over,
	// configuration
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [fpba_pkg::PADDR_W-1:0]      paddr,
	input  wire logic [fpba_pkg::PDATA_W-1:0]      pwdata,
	output logic [fpba_pkg::PDATA_W-1:0]           prdata,
	output logic                                   pready
);

	fpba_pkg::state_t               state_q, state_d;
	logic [fpba_pkg::IDX_W-1:0]     scan_cnt_q, scan_cnt_d;
	logic [fpba_pkg::WIDE_W-1:0]    amount_q;
	logic [fpba_pkg::MODE_W-1:0]    fit_mode;
	logic [fpba_pkg::CNT_W-1:0]     block_count;

	logic                           out_valid_q;
	logic                           granted_q;
	logic [fpba_pkg::IDXF_W-1:0]    chosen_q;
	logic [fpba_pkg::AMT_W-1:0]     left_q;

	logic                           in_acc;
	logic                           load_acc;
	logic                           req_acc;
	logic                           load_in_range;
	logic                           out_free;
	logic                           finish;
	logic [fpba_pkg::SIZE_BITS-1:0] new_cap;

	fpba_pkg::cell_ctl_t            ctl;
	fpba_pkg::cand_t                chain [fpba_pkg::NUM_BLOCKS+1];
	fpba_pkg::cand_t                result;

	fpba_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.fit_mode    (fit_mode),
		.block_count (block_count)
	);

	// handshake
	assign in_stall = (state_q != fpba_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign load_acc = in_acc && !action;
	assign req_acc  = in_acc && action;
	assign load_in_range = fpba_pkg::CMP_W'(block_index) <
		fpba_pkg::CMP_W'(fpba_pkg::NUM_BLOCKS);
	assign out_free = !out_valid_q || !out_stall;

	// search chain: an empty candidate enters at cell zero every cycle
	assign chain[0] = '0;
	assign result   = chain[fpba_pkg::NUM_BLOCKS];
	assign new_cap  = fpba_pkg::SIZE_BITS'(fpba_pkg::WIDE_W'(result.cap) - amount_q);

	for (genvar k = 0; k < fpba_pkg::NUM_BLOCKS; k++) begin : g_cell
		fpba_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.my_idx   (fpba_pkg::IDX_W'(k)),
			.ctl      (ctl),
			.cand_in  (chain[k]),
			.cand_out (chain[k+1])
		);
	end

	// sequencer
	always_comb begin
		state_d    = state_q;
		scan_cnt_d = scan_cnt_q;
		finish     = 1'b0;
		unique case (state_q)
			fpba_pkg::ST_IDLE: begin
				if (req_acc) begin
					state_d    = fpba_pkg::ST_SCAN;
					scan_cnt_d = '0;
				end
			end
			fpba_pkg::ST_SCAN: begin
				if (scan_cnt_q == fpba_pkg::IDX_W'(fpba_pkg::NUM_BLOCKS - 1)) begin
					state_d = fpba_pkg::ST_WRITE;
				end else begin
					scan_cnt_d = scan_cnt_q + 1'b1;
				end
			end
			fpba_pkg::ST_WRITE: begin
				if (out_free) begin
					finish  = 1'b1;
					state_d = fpba_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fpba_pkg::ST_IDLE;
			end
		endcase
	end

	// cell broadcast: loads write straight from the port, grants charge the winner
	always_comb begin
		ctl.mode   = fit_mode;
		ctl.amount = amount_q;
		ctl.count  = block_count;
		if (finish) begin
			ctl.wr_en   = result.found;
			ctl.wr_idx  = result.idx;
			ctl.wr_data = new_cap;
		end else begin
			ctl.wr_en   = load_acc && load_in_range;
			ctl.wr_idx  = fpba_pkg::IDX_W'(block_index);
			ctl.wr_data = fpba_pkg::SIZE_BITS'(amount);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= fpba_pkg::ST_IDLE;
			scan_cnt_q <= '0;
		end else begin
			state_q    <= state_d;
			scan_cnt_q <= scan_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			amount_q <= fpba_pkg::WIDE_W'(amount);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			granted_q <= result.found;
			if (result.found) begin
				chosen_q <= fpba_pkg::IDXF_W'(result.idx);
				left_q   <= fpba_pkg::AMT_W'(new_cap);
			end else begin
				chosen_q <= '0;
				left_q   <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign granted      = granted_q;
	assign chosen_block = chosen_q;
	assign left_over    = left_q;

	// a refused request reports zeros
	a_nogrant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !granted |-> chosen_block == '0 && left_over == '0)
		else $error("not-granted result carries nonzero fields");

	// an accepted request always starts a scan
	a_req_scan: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> state_q == fpba_pkg::ST_SCAN && scan_cnt_q == '0)
		else $error("request did not start a scan");

	// a new result only comes out of the charge cycle
	a_out_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == fpba_pkg::ST_WRITE))
		else $error("result appeared outside the charge cycle");

	// the scan counter never runs past the last cell
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fpba_pkg::ST_SCAN |->
		fpba_pkg::CMP_W'(scan_cnt_q) < fpba_pkg::CMP_W'(fpba_pkg::NUM_BLOCKS))
		else $error("scan counter out of range");

endmodule
`default_nettype wire
